[rtl/ilc_pkg.sv]
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types, character constants and character class functions for the
// INI line classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ilc_pkg;

  // character constants
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // kind of a result transaction
  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_NAME    = 2'd2,
    KIND_VERDICT = 2'd3
  } kind_t;

  // line verdict codes
  typedef enum logic [2:0] {
    VERD_BLANK    = 3'd0,
    VERD_PAIR     = 3'd1,
    VERD_SECTION  = 3'd2,
    VERD_PAIR_ERR = 3'd3,
    VERD_SECT_ERR = 3'd4
  } verdict_t;

  // character accepted by the pair recognizer
  typedef struct packed {
    logic vld;
    logic is_value;
  } pair_emit_t;

  // pair recognizer status seen at line end
  typedef struct packed {
    logic blank;
    logic ok;
    logic defer;
  } pair_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_comment(input logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_HASH);
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return is_alpha(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // letters, digits, the punctuation set, and space inside quotes
  function automatic logic is_value_char(input logic [7:0] c, input logic quoted);
    logic punct;
    case (c) inside
      8'h5F, 8'h2D, 8'h2B, 8'h2E, 8'h2C, 8'h3A, 8'h27, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h5C, 8'h2F: punct = 1'b1;
      default: punct = 1'b0;
    endcase
    return is_alpha(c) || is_digit(c) || punct || (quoted && (c == CH_SPACE));
  endfunction

endpackage

`default_nettype wire

[rtl/ilc_pair.sv]
// ----------------------------------------------------------------------------
// ilc_pair
// Recognizer for a "key = value" line, one character per step, with the
// text length counter shared through len_in / len_out.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_pair #(
  parameter int LINE_MAX   = 256,
  parameter int STRING_MAX = 64
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            step,
  input  wire                            clear,
  input  wire  [7:0]                     ch,
  input  wire  [$clog2(LINE_MAX)-1:0]    pos,
  input  wire  [$clog2(STRING_MAX)-1:0]  len_in,
  output logic [$clog2(STRING_MAX)-1:0]  len_out,
  output ilc_pkg::pair_emit_t            emit,
  output ilc_pkg::pair_stat_t            stat,
  output logic [$clog2(LINE_MAX)-1:0]    fail_off
);

  localparam int PW = $clog2(LINE_MAX);
  localparam int LW = $clog2(STRING_MAX);

  typedef enum logic [3:0] {
    PP_LEAD, PP_KEY, PP_AFTER_KEY, PP_BEFORE_VALUE, PP_VALUE, PP_TRAIL,
    PP_COMMENT_OK, PP_COMMENT_FAIL, PP_BLANK, PP_FAILED
  } pair_phase_t;

  pair_phase_t   ph_r, ph_nxt;
  logic          quoted_r, quoted_nxt;
  logic [PW-1:0] off_r, off_nxt;
  logic          bracket_r, bracket_nxt;

  logic          clr, app, fail, ok;
  logic [LW-1:0] len_base;
  logic          c_space, c_comment;

  assign c_space   = ilc_pkg::is_space(ch);
  assign c_comment = ilc_pkg::is_comment(ch);

  // next phase for one character
  always_comb begin
    ph_nxt      = ph_r;
    quoted_nxt  = quoted_r;
    off_nxt     = off_r;
    bracket_nxt = bracket_r;
    clr         = 1'b0;
    app         = 1'b0;
    fail        = 1'b0;
    unique case (ph_r)
      PP_LEAD: begin
        if (!c_space) begin
          if (c_comment) begin
            ph_nxt = PP_BLANK;
          end else if (ilc_pkg::is_word_start(ch)) begin
            clr    = 1'b1;
            app    = 1'b1;
            ph_nxt = PP_KEY;
          end else begin
            fail = 1'b1;
          end
        end
      end
      PP_KEY, PP_AFTER_KEY: begin
        if (ph_r == PP_KEY && ilc_pkg::is_word_char(ch)) begin
          app = 1'b1;
        end else begin
          ph_nxt = PP_AFTER_KEY;
          if (!c_space) begin
            if (c_comment) begin
              ph_nxt = PP_COMMENT_FAIL;
            end else if (ch == ilc_pkg::CH_EQUAL) begin
              ph_nxt = PP_BEFORE_VALUE;
              clr    = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
        end
      end
      PP_BEFORE_VALUE: begin
        if (!c_space) begin
          if (c_comment) begin
            ph_nxt = PP_COMMENT_OK;
          end else if (ch == ilc_pkg::CH_QUOTE) begin
            quoted_nxt = 1'b1;
            ph_nxt     = PP_VALUE;
          end else begin
            quoted_nxt = 1'b0;
            if (ilc_pkg::is_value_char(ch, 1'b0)) begin
              app    = 1'b1;
              ph_nxt = PP_VALUE;
            end else begin
              fail = 1'b1;
            end
          end
        end
      end
      PP_VALUE, PP_TRAIL: begin
        if (ph_r == PP_VALUE && ilc_pkg::is_value_char(ch, quoted_r)) begin
          app = 1'b1;
        end else if (ph_r == PP_VALUE && quoted_r) begin
          if (ch == ilc_pkg::CH_QUOTE) ph_nxt = PP_TRAIL;
          else fail = 1'b1;
        end else begin
          ph_nxt = PP_TRAIL;
          if (!c_space) begin
            if (c_comment) ph_nxt = PP_COMMENT_OK;
            else fail = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // text length limit
    len_base = clr ? '0 : len_in;
    ok       = len_base < LW'(STRING_MAX - 1);
    if (app && !ok) begin
      ph_nxt      = PP_FAILED;
      off_nxt     = '0;
      bracket_nxt = 1'b0;
    end
    if (fail) begin
      ph_nxt      = PP_FAILED;
      off_nxt     = pos;
      bracket_nxt = (ch == ilc_pkg::CH_LBRACK);
    end
  end

  // shared length and emitted character
  always_comb begin
    if (!step) len_out = len_in;
    else if (app && ok) len_out = len_base + LW'(1);
    else len_out = len_base;
    emit.vld      = step && app && ok;
    emit.is_value = (ph_r == PP_BEFORE_VALUE) || (ph_r == PP_VALUE);
  end

  // status at line end
  always_comb begin
    stat.blank = (ph_r == PP_LEAD) || (ph_r == PP_BLANK);
    stat.ok    = (ph_r == PP_BEFORE_VALUE) || (ph_r == PP_TRAIL) ||
                 (ph_r == PP_COMMENT_OK) || (ph_r == PP_VALUE && !quoted_r);
    stat.defer = (ph_r == PP_FAILED) && bracket_r;
    fail_off   = (ph_r == PP_FAILED) ? off_r : pos;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      ph_r      <= PP_LEAD;
      quoted_r  <= 1'b0;
      off_r     <= '0;
      bracket_r <= 1'b0;
    end else if (step) begin
      ph_r      <= ph_nxt;
      quoted_r  <= quoted_nxt;
      off_r     <= off_nxt;
      bracket_r <= bracket_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/ilc_sect.sv]
// ----------------------------------------------------------------------------
// ilc_sect
// Recognizer for a "[name]" section header line, one character per step,
// with the text length counter shared through len_in / len_out.
// ----------------------------------------------------------------------------
`default_nettype none

module ilc_sect #(
  parameter int LINE_MAX   = 256,
  parameter int STRING_MAX = 64
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            step,
  input  wire                            clear,
  input  wire  [7:0]                     ch,
  input  wire  [$clog2(LINE_MAX)-1:0]    pos,
  input  wire  [$clog2(STRING_MAX)-1:0]  len_in,
  output logic [$clog2(STRING_MAX)-1:0]  len_out,
  output logic                           emit,
  output logic                           ok_end,
  output logic [$clog2(LINE_MAX)-1:0]    fail_off
);

  localparam int PW = $clog2(LINE_MAX);
  localparam int LW = $clog2(STRING_MAX);

  typedef enum logic [2:0] {
    SP_LEAD, SP_OPEN, SP_NAME, SP_BEFORE_CLOSE, SP_TRAIL,
    SP_COMMENT_OK, SP_COMMENT_FAIL, SP_FAILED
  } sect_phase_t;

  sect_phase_t   ph_r, ph_nxt, eph;
  logic [PW-1:0] off_r, off_nxt;

  logic          clr, app, fail, ok;
  logic [LW-1:0] len_base;
  logic          c_space, c_comment;

  assign c_space   = ilc_pkg::is_space(ch);
  assign c_comment = ilc_pkg::is_comment(ch);

  // next phase for one character
  always_comb begin
    ph_nxt  = ph_r;
    off_nxt = off_r;
    clr     = 1'b0;
    app     = 1'b0;
    fail    = 1'b0;
    eph     = (ph_r == SP_NAME) ? SP_BEFORE_CLOSE : ph_r;
    unique case (ph_r)
      SP_LEAD, SP_OPEN, SP_NAME, SP_BEFORE_CLOSE: begin
        if (ph_r == SP_NAME && ilc_pkg::is_word_char(ch)) begin
          app = 1'b1;
        end else begin
          ph_nxt = eph;
          if (!c_space) begin
            if (c_comment) begin
              ph_nxt = SP_COMMENT_FAIL;
            end else if (eph == SP_LEAD && ch == ilc_pkg::CH_LBRACK) begin
              ph_nxt = SP_OPEN;
            end else if (eph == SP_BEFORE_CLOSE && ch == ilc_pkg::CH_RBRACK) begin
              ph_nxt = SP_TRAIL;
            end else if (eph == SP_OPEN && ilc_pkg::is_word_start(ch)) begin
              clr    = 1'b1;
              app    = 1'b1;
              ph_nxt = SP_NAME;
            end else begin
              fail = 1'b1;
            end
          end
        end
      end
      SP_TRAIL: begin
        if (!c_space) begin
          if (c_comment) ph_nxt = SP_COMMENT_OK;
          else fail = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // name length limit
    len_base = clr ? '0 : len_in;
    ok       = len_base < LW'(STRING_MAX - 1);
    if (app && !ok) begin
      ph_nxt  = SP_FAILED;
      off_nxt = '0;
    end
    if (fail) begin
      ph_nxt  = SP_FAILED;
      off_nxt = pos;
    end
  end

  // shared length and emitted character
  always_comb begin
    if (!step) len_out = len_in;
    else if (app && ok) len_out = len_base + LW'(1);
    else len_out = len_base;
    emit = step && app && ok;
  end

  // status at line end
  assign ok_end   = (ph_r == SP_TRAIL) || (ph_r == SP_COMMENT_OK);
  assign fail_off = (ph_r == SP_FAILED) ? off_r : pos;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      ph_r  <= SP_LEAD;
      off_r <= '0;
    end else if (step) begin
      ph_r  <= ph_nxt;
      off_r <= off_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/ini_line_classifier.sv]
// ----------------------------------------------------------------------------
// ini_line_classifier
// Streams one INI line character per transaction and classifies the line.
// ----------------------------------------------------------------------------
// Feed one character per input transaction (in_tdata) and mark the end of
// a line with in_tlast, whose character is ignored. Each accepted key, value
// or section-name character comes out as it is recognized, and a verdict
// transaction follows the end of each line: blank, pair, section, pair error
// or section error with the failing character offset (saturating at 255).
// The block takes one character every clock cycle while the output side
// keeps up; a result is held first in the input register and then in the
// result register, and both recognizers update their state in the same
// step in which the character leaves the input register. Characters beyond
// the first LINE_MAX-1 of a line are dropped, and key, value and name text
// is limited to STRING_MAX-1 characters.
`default_nettype none

module ini_line_classifier #(
  parameter int LINE_MAX   = 256,
  parameter int STRING_MAX = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] ch
  input  wire         in_tlast,   // line_end
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [7:0] char_out, [10:8] verdict,
                                  // [18:11] err_offset, [23:19] zero
  output logic [1:0]  out_tuser   // [1:0] kind
);

  localparam int PW = $clog2(LINE_MAX);
  localparam int LW = $clog2(STRING_MAX);
  localparam int OW = (PW > 8) ? PW : 8;

  // input register
  logic       s_valid_r;
  logic [7:0] s_ch_r;
  logic       s_end_r;

  // line state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] len_r, len_nxt, len_mid, len_sect;

  // result register
  logic              out_valid_r, out_valid_nxt;
  ilc_pkg::kind_t    kind_r, kind_nxt;
  logic [7:0]        char_r, char_nxt;
  ilc_pkg::verdict_t verd_r, verd_nxt;
  logic [7:0]        eoff_r, eoff_nxt;

  logic out_free, go, step, line_done;

  ilc_pkg::pair_emit_t p_emit;
  ilc_pkg::pair_stat_t p_stat;
  logic [PW-1:0]       p_off, s_off;
  logic                s_emit, s_ok;
  logic [PW-1:0]       err_pos;
  logic [OW-1:0]       err_wide;

  // handshake and step control
  assign out_free  = !out_valid_r || out_tready;
  assign go        = s_valid_r && out_free;
  assign in_tready = !s_valid_r || out_free;
  assign line_done = go && s_end_r;
  assign step      = go && !s_end_r && (pos_r < PW'(LINE_MAX - 1));

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s_valid_r <= 1'b1;
    end else if (go) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_ch_r  <= in_tdata;
      s_end_r <= in_tlast;
    end
  end

  // recognizers
  ilc_pair #(
    .LINE_MAX   (LINE_MAX),
    .STRING_MAX (STRING_MAX)
  ) u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .clear    (line_done),
    .ch       (s_ch_r),
    .pos      (pos_r),
    .len_in   (len_r),
    .len_out  (len_mid),
    .emit     (p_emit),
    .stat     (p_stat),
    .fail_off (p_off)
  );

  ilc_sect #(
    .LINE_MAX   (LINE_MAX),
    .STRING_MAX (STRING_MAX)
  ) u_sect (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .clear    (line_done),
    .ch       (s_ch_r),
    .pos      (pos_r),
    .len_in   (len_mid),
    .len_out  (len_sect),
    .emit     (s_emit),
    .ok_end   (s_ok),
    .fail_off (s_off)
  );

  // position and text length
  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    if (line_done) begin
      pos_nxt = '0;
      len_nxt = '0;
    end else if (step) begin
      pos_nxt = pos_r + PW'(1);
      len_nxt = len_sect;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

  // verdict and result selection
  always_comb begin
    verd_nxt = ilc_pkg::VERD_BLANK;
    err_pos  = '0;
    kind_nxt = ilc_pkg::KIND_VERDICT;
    char_nxt = 8'h00;
    if (s_end_r) begin
      if (p_stat.blank) begin
        verd_nxt = ilc_pkg::VERD_BLANK;
      end else if (p_stat.ok) begin
        verd_nxt = ilc_pkg::VERD_PAIR;
      end else if (!p_stat.defer) begin
        verd_nxt = ilc_pkg::VERD_PAIR_ERR;
        err_pos  = p_off;
      end else if (s_ok) begin
        verd_nxt = ilc_pkg::VERD_SECTION;
      end else begin
        verd_nxt = ilc_pkg::VERD_SECT_ERR;
        err_pos  = s_off;
      end
    end else begin
      char_nxt = s_ch_r;
      if (s_emit) kind_nxt = ilc_pkg::KIND_NAME;
      else if (p_emit.is_value) kind_nxt = ilc_pkg::KIND_VALUE;
      else kind_nxt = ilc_pkg::KIND_KEY;
    end
    err_wide = OW'(err_pos);
    eoff_nxt = (err_wide > OW'(255)) ? 8'hFF : err_wide[7:0];

    if (go) out_valid_nxt = line_done || p_emit.vld || s_emit;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      kind_r <= kind_nxt;
      char_r <= char_nxt;
      verd_r <= verd_nxt;
      eoff_r <= eoff_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {5'b0, eoff_r, verd_r, char_r};

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(LINE_MAX - 1))
    else $error("line position beyond limit");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(STRING_MAX - 1))
    else $error("text length beyond limit");

  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    line_done |=> (pos_r == '0) && (len_r == '0))
    else $error("line state not cleared after line end");

  a_offset_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (eoff_r != 8'h00) |->
      (verd_r == ilc_pkg::VERD_PAIR_ERR) || (verd_r == ilc_pkg::VERD_SECT_ERR))
    else $error("error offset on a non-error result");

  a_no_double_emit: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(p_emit.vld && s_emit))
    else $error("both recognizers accepted the same character");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while both stages are blocked");

endmodule

`default_nettype wire

[test/tb_ini_line_classifier.sv]
// ----------------------------------------------------------------------------
// tb_ini_line_classifier
// Self-checking testbench for the INI line classifier.
// ----------------------------------------------------------------------------
// Lines are fed one character per input transaction and closed with tlast.
// A cycle-free line parser in the bench predicts every emitted key, value
// and section-name character and the verdict of each line. Results are
// compared field by field in arrival order. Directed lines cover the corner
// cases and are followed by randomized, mostly well-formed lines with
// random stalls on both channels, then by a stall-free stretch.
`timescale 1ns / 1ps

module tb_ini_line_classifier;

  localparam int LINE_LIMIT = 256;
  localparam int STR_LIMIT  = 64;
  localparam string PUNCT   = "_-+.,:'()[]{}\\/";

  // parser states of the pair and section recognizers
  typedef enum logic [3:0] {
    P_LEAD, P_KEY, P_AFTER_KEY, P_PRE_VAL, P_VAL, P_TRAIL,
    P_CMT_OK, P_CMT_BAD, P_BLANK, P_DEAD
  } pair_ph_t;

  typedef enum logic [2:0] {
    S_LEAD, S_OPEN, S_NAME, S_PRE_CLOSE, S_TRAIL,
    S_CMT_OK, S_CMT_BAD, S_DEAD
  } sect_ph_t;

  // one parsed token or line verdict
  typedef struct {
    ilc_pkg::kind_t    kind;
    logic [7:0]        chr;
    ilc_pkg::verdict_t verd;
    logic [7:0]        off;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  // character classes
  bit [255:0] ws_set, note_set, head_set, body_set, val_set;

  // parser state
  pair_ph_t pair_ph;
  sect_ph_t sect_ph;
  int       col;
  int       pair_err_at;
  int       sect_err_at;
  int       txt_len;
  bit       in_quotes;
  bit       pair_err_brk;
  bit       has_tok;
  ilc_pkg::kind_t tok_kind;
  logic [7:0] tok_chr;

  token_t     token_q[$];
  token_t     seen_tok;
  logic [7:0] line_buf[$];
  int         fail_cnt;
  int         items_sent;
  int         gap_pct;
  bit         calm;

  ini_line_classifier #(
    .LINE_MAX  (LINE_LIMIT),
    .STRING_MAX(STR_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int rr(int lo, int hi);
    return int'($urandom_range(hi, lo));
  endfunction

  // ---------------------------------------------------------------- parser

  function automatic void load_char_sets();
    for (int i = 0; i < 256; i++) begin
      ws_set[i]   = (i == 32) || (i >= 9 && i <= 13);
      head_set[i] = (i >= 65 && i <= 90) || (i >= 97 && i <= 122) || (i == 95);
      body_set[i] = head_set[i] || (i >= 48 && i <= 57);
      note_set[i] = (i == ilc_pkg::CH_SEMI) || (i == ilc_pkg::CH_HASH);
    end
    val_set = body_set;
    for (int j = 0; j < PUNCT.len(); j++) val_set[PUNCT[j]] = 1'b1;
  endfunction

  function automatic bit val_ok(logic [7:0] c, bit quoted);
    return val_set[c] || (quoted && c == ilc_pkg::CH_SPACE);
  endfunction

  function automatic void parser_clear();
    pair_ph      = P_LEAD;
    sect_ph      = S_LEAD;
    col          = 0;
    pair_err_at  = 0;
    sect_err_at  = 0;
    txt_len      = 0;
    in_quotes    = 1'b0;
    pair_err_brk = 1'b0;
  endfunction

  // take one text character unless the string is already full
  function automatic bit grab_text(logic [7:0] c, ilc_pkg::kind_t k);
    if (txt_len >= STR_LIMIT - 1) return 1'b0;
    txt_len++;
    has_tok  = 1'b1;
    tok_kind = k;
    tok_chr  = c;
    return 1'b1;
  endfunction

  function automatic void pair_die(logic [7:0] c, bit eol);
    pair_err_at  = col;
    pair_err_brk = !eol && (c == ilc_pkg::CH_LBRACK);
    pair_ph      = P_DEAD;
  endfunction

  function automatic void pair_too_long();
    pair_err_at  = 0;
    pair_err_brk = 1'b0;
    pair_ph      = P_DEAD;
  endfunction

  function automatic void sect_die();
    sect_err_at = col;
    sect_ph     = S_DEAD;
  endfunction

  // pair recognizer, returns 1 when the line end completes a pair
  function automatic bit pair_feed(logic [7:0] c, bit eol);
    bit again;
    bit ok;
    ok = 1'b0;
    do begin
      again = 1'b0;
      case (pair_ph)
        P_LEAD: begin
          if (!(eol || ws_set[c])) begin
            if (note_set[c]) pair_ph = P_BLANK;
            else if (head_set[c]) begin
              txt_len = 0;
              if (grab_text(c, ilc_pkg::KIND_KEY)) pair_ph = P_KEY;
              else pair_too_long();
            end else pair_die(c, eol);
          end
        end
        P_KEY: begin
          if (!eol && body_set[c]) begin
            if (!grab_text(c, ilc_pkg::KIND_KEY)) pair_too_long();
          end else begin
            pair_ph = P_AFTER_KEY;
            again   = 1'b1;
          end
        end
        P_AFTER_KEY: begin
          if (eol) pair_die(c, eol);
          else if (!ws_set[c]) begin
            if (note_set[c]) pair_ph = P_CMT_BAD;
            else if (c == ilc_pkg::CH_EQUAL) begin
              pair_ph = P_PRE_VAL;
              txt_len = 0;
            end else pair_die(c, eol);
          end
        end
        P_PRE_VAL: begin
          if (eol) ok = 1'b1;
          else if (!ws_set[c]) begin
            if (note_set[c]) pair_ph = P_CMT_OK;
            else if (c == ilc_pkg::CH_QUOTE) begin
              in_quotes = 1'b1;
              pair_ph   = P_VAL;
            end else begin
              in_quotes = 1'b0;
              pair_ph   = val_set[c] ? P_VAL : P_TRAIL;
              again     = 1'b1;
            end
          end
        end
        P_VAL: begin
          if (!eol && val_ok(c, in_quotes)) begin
            if (!grab_text(c, ilc_pkg::KIND_VALUE)) pair_too_long();
          end else if (in_quotes) begin
            if (!eol && c == ilc_pkg::CH_QUOTE) pair_ph = P_TRAIL;
            else pair_die(c, eol);
          end else begin
            pair_ph = P_TRAIL;
            again   = 1'b1;
          end
        end
        P_TRAIL: begin
          if (eol) ok = 1'b1;
          else if (!ws_set[c]) begin
            if (note_set[c]) pair_ph = P_CMT_OK;
            else pair_die(c, eol);
          end
        end
        P_CMT_OK:  ok = eol;
        P_CMT_BAD: if (eol) pair_die(c, eol);
        default: ;
      endcase
    end while (again);
    return ok;
  endfunction

  // section recognizer, returns 1 when the line end completes a header
  function automatic bit sect_feed(logic [7:0] c, bit eol);
    bit again;
    bit ok;
    ok = 1'b0;
    do begin
      again = 1'b0;
      case (sect_ph)
        S_LEAD, S_OPEN, S_PRE_CLOSE: begin
          if (eol) sect_die();
          else if (!ws_set[c]) begin
            if (note_set[c]) sect_ph = S_CMT_BAD;
            else if (sect_ph == S_LEAD && c == ilc_pkg::CH_LBRACK) sect_ph = S_OPEN;
            else if (sect_ph == S_PRE_CLOSE && c == ilc_pkg::CH_RBRACK) sect_ph = S_TRAIL;
            else if (sect_ph == S_OPEN && head_set[c]) begin
              txt_len = 0;
              if (grab_text(c, ilc_pkg::KIND_NAME)) sect_ph = S_NAME;
              else begin
                sect_err_at = 0;
                sect_ph     = S_DEAD;
              end
            end else sect_die();
          end
        end
        S_NAME: begin
          if (!eol && body_set[c]) begin
            if (!grab_text(c, ilc_pkg::KIND_NAME)) begin
              sect_err_at = 0;
              sect_ph     = S_DEAD;
            end
          end else begin
            sect_ph = S_PRE_CLOSE;
            again   = 1'b1;
          end
        end
        S_TRAIL: begin
          if (eol) ok = 1'b1;
          else if (!ws_set[c]) begin
            if (note_set[c]) sect_ph = S_CMT_OK;
            else sect_die();
          end
        end
        S_CMT_OK:  ok = eol;
        S_CMT_BAD: if (eol) sect_die();
        default: ;
      endcase
    end while (again);
    return ok;
  endfunction

  // advance the parser by one accepted transaction and queue its result
  function automatic void parse_char(logic [7:0] c, bit eol);
    token_t            t;
    ilc_pkg::verdict_t v;
    int                off;
    if (eol) begin
      off = 0;
      if (pair_ph == P_LEAD || pair_ph == P_BLANK) v = ilc_pkg::VERD_BLANK;
      else if (pair_feed(8'h00, 1'b1)) v = ilc_pkg::VERD_PAIR;
      else if (!pair_err_brk) begin
        v   = ilc_pkg::VERD_PAIR_ERR;
        off = pair_err_at;
      end else if (sect_feed(8'h00, 1'b1)) v = ilc_pkg::VERD_SECTION;
      else begin
        v   = ilc_pkg::VERD_SECT_ERR;
        off = sect_err_at;
      end
      t.kind = ilc_pkg::KIND_VERDICT;
      t.chr  = 8'h00;
      t.verd = v;
      t.off  = (off > 255) ? 8'hFF : off[7:0];
      token_q.push_back(t);
      parser_clear();
    end else if (col < LINE_LIMIT - 1) begin
      has_tok = 1'b0;
      void'(pair_feed(c, 1'b0));
      void'(sect_feed(c, 1'b0));
      col++;
      if (has_tok) begin
        t.kind = tok_kind;
        t.chr  = tok_chr;
        t.verd = ilc_pkg::VERD_BLANK;
        t.off  = 8'h00;
        token_q.push_back(t);
      end
    end
  endfunction

  // --------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (token_q.size() == 0) begin
        $error("unexpected result: kind %0d data %h", out_tuser, out_tdata);
        fail_cnt++;
      end else begin
        seen_tok = token_q.pop_front();
        if (out_tuser !== seen_tok.kind) begin
          $error("kind: expected %0d, got %0d", seen_tok.kind, out_tuser);
          fail_cnt++;
        end
        if (out_tdata[7:0] !== seen_tok.chr) begin
          $error("char_out: expected %h, got %h", seen_tok.chr, out_tdata[7:0]);
          fail_cnt++;
        end
        if (out_tdata[10:8] !== seen_tok.verd) begin
          $error("verdict: expected %0d, got %0d", seen_tok.verd, out_tdata[10:8]);
          fail_cnt++;
        end
        if (out_tdata[18:11] !== seen_tok.off) begin
          $error("err_offset: expected %0d, got %0d", seen_tok.off, out_tdata[18:11]);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stalls in bursts, with stall-free stretches in between
  always begin
    @(negedge clk);
    if (rst_n && !calm) begin
      case (rr(0, 9))
        0: begin
          out_tready <= 1'b0;
          repeat (rr(1, 13)) @(negedge clk);
          out_tready <= 1'b1;
        end
        1: repeat (rr(20, 120)) @(negedge clk);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- driver

  // one input transaction, called and returning at a falling edge
  task automatic send_char(logic [7:0] c, bit eol);
    logic [7:0] d;
    d = eol ? 8'($urandom) : c;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= eol;
    do @(posedge clk); while (!in_tready);
    parse_char(d, eol);
    items_sent++;
    @(negedge clk);
    if (!calm && rr(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat (rr(1, 13)) @(negedge clk);
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], 1'b0);
    send_char(8'h00, 1'b1);
    line_buf.delete();
  endtask

  // hold off input until every queued result has been checked
  task automatic wait_idle();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (token_q.size() != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
    repeat (4) @(negedge clk);
  endtask

  // ----------------------------------------------------------- line builder

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_rep(logic [7:0] c, int n);
    repeat (n) line_buf.push_back(c);
  endtask

  task automatic put_ws(int n);
    int w;
    repeat (n) begin
      w = rr(8, 14);
      line_buf.push_back((w < 9 || w > 13) ? ilc_pkg::CH_SPACE : 8'(w));
    end
  endtask

  task automatic put_ident(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(255, 0));
      while (!(i == 0 ? head_set[c] : body_set[c]));
      line_buf.push_back(c);
    end
  endtask

  task automatic put_value(int n, bit quoted);
    logic [7:0] c;
    repeat (n) begin
      if (quoted && rr(0, 5) == 0) c = ilc_pkg::CH_SPACE;
      else begin
        do c = 8'($urandom_range(255, 0));
        while (!val_set[c]);
      end
      line_buf.push_back(c);
    end
  endtask

  task automatic put_comment();
    line_buf.push_back(rr(0, 1) ? ilc_pkg::CH_SEMI : ilc_pkg::CH_HASH);
    repeat (rr(0, 5)) line_buf.push_back(8'(rr(0, 3) == 0 ? rr(0, 255) : rr(32, 126)));
  endtask

  // damage a well-formed line by overwriting or inserting one character
  task automatic corrupt_line();
    int p;
    logic [7:0] c;
    if (line_buf.size() == 0) return;
    p = rr(0, line_buf.size() - 1);
    if (rr(0, 1)) line_buf[p] = 8'($urandom_range(255, 0));
    else begin
      case (rr(0, 5))
        0: c = ilc_pkg::CH_LBRACK;
        1: c = ilc_pkg::CH_RBRACK;
        2: c = ilc_pkg::CH_EQUAL;
        3: c = ilc_pkg::CH_QUOTE;
        4: c = ilc_pkg::CH_SEMI;
        default: c = ilc_pkg::CH_SPACE;
      endcase
      line_buf.insert(p, c);
    end
  endtask

  task automatic build_pair(int maxlen);
    put_ws(rr(0, 2));
    put_ident(rr(1, maxlen));
    put_ws(rr(0, 2));
    line_buf.push_back(ilc_pkg::CH_EQUAL);
    put_ws(rr(0, 2));
    case (rr(0, 3))
      0: ;
      1: begin
        line_buf.push_back(ilc_pkg::CH_QUOTE);
        put_value(rr(0, maxlen), 1'b1);
        if (rr(0, 7) != 0) line_buf.push_back(ilc_pkg::CH_QUOTE);
      end
      default: put_value(rr(1, maxlen), 1'b0);
    endcase
    put_ws(rr(0, 2));
    if (rr(0, 3) == 0) put_comment();
  endtask

  task automatic build_section(int maxlen);
    put_ws(rr(0, 2));
    line_buf.push_back(ilc_pkg::CH_LBRACK);
    put_ws(rr(0, 1));
    put_ident(rr(1, maxlen));
    put_ws(rr(0, 1));
    if (rr(0, 9) != 0) line_buf.push_back(ilc_pkg::CH_RBRACK);
    put_ws(rr(0, 2));
    if (rr(0, 3) == 0) put_comment();
  endtask

  task automatic build_random_line();
    int maxlen;
    int pick;
    maxlen = (rr(0, 24) == 0) ? STR_LIMIT + 2 : 8;
    pick   = rr(0, 9);
    if (pick < 4) build_pair(maxlen);
    else if (pick < 7) build_section(maxlen);
    else if (pick == 7) begin
      put_ws(rr(0, 3));
      if (rr(0, 1)) put_comment();
    end else if (pick == 8) begin
      repeat (rr(0, 20)) line_buf.push_back(8'($urandom_range(255, 0)));
    end else begin
      // key without an assignment
      put_ws(rr(0, 2));
      put_ident(rr(1, maxlen));
      put_ws(rr(0, 2));
      if (rr(0, 1)) put_comment();
      else put_ident(rr(1, 3));
    end
    if (pick < 7 && rr(0, 4) == 0) corrupt_line();
  endtask

  // ----------------------------------------------------------------- tests

  // short lines for each verdict and the corner cases
  task automatic test_basic_lines();
    gap_pct = 20;
    send_line();
    put_str(" \t#");
    send_line();
    put_str("k=v");
    send_line();
    put_str("[s]");
    send_line();
    put_str("[s");
    send_line();
    put_str("[s;");
    send_line();
    put_str("a;");
    send_line();
    put_str("a=;");
    send_line();
    put_str("a=\"b c");
    send_line();
    line_buf.push_back(8'hFF);
    send_line();
    line_buf.push_back(8'h00);
    send_line();
  endtask

  // key, value and name lengths at and just past the string limit
  task automatic test_long_text();
    gap_pct = 10;
    put_rep("k", STR_LIMIT - 1);
    put_str("=1");
    send_line();
    put_rep("k", STR_LIMIT);
    put_str("=1");
    send_line();
    put_str("a=");
    put_rep("v", STR_LIMIT);
    send_line();
    line_buf.push_back(ilc_pkg::CH_QUOTE);
    line_buf.push_front(ilc_pkg::CH_EQUAL);
    line_buf.push_front("b");
    put_rep("w", STR_LIMIT - 1);
    line_buf.push_back(ilc_pkg::CH_QUOTE);
    send_line();
    line_buf.push_back(ilc_pkg::CH_LBRACK);
    put_rep("n", STR_LIMIT - 1);
    line_buf.push_back(ilc_pkg::CH_RBRACK);
    send_line();
    line_buf.push_back(ilc_pkg::CH_LBRACK);
    put_rep("n", STR_LIMIT);
    line_buf.push_back(ilc_pkg::CH_RBRACK);
    send_line();
  endtask

  // characters beyond the line limit are dropped
  task automatic test_long_line();
    gap_pct = 5;
    put_str("k=v");
    put_rep(ilc_pkg::CH_SPACE, 296);
    put_str("x");
    send_line();
    put_rep(ilc_pkg::CH_SPACE, LINE_LIMIT - 1);
    line_buf.push_back(ilc_pkg::CH_LBRACK);
    send_line();
    put_rep(ilc_pkg::CH_SPACE, LINE_LIMIT - 2);
    put_str("a");
    send_line();
  endtask

  // input waits for the result side to empty
  task automatic test_drain_pause();
    gap_pct = 0;
    repeat (3) begin
      build_random_line();
      send_line();
      wait_idle();
    end
  endtask

  task automatic test_random_lines();
    int stop_at;
    stop_at = items_sent + 320;
    while (items_sent < stop_at) begin
      gap_pct = (rr(0, 3) == 0) ? 0 : 25;
      build_random_line();
      send_line();
    end
  endtask

  // back-to-back traffic with no stalls on either side
  task automatic test_steady_stream();
    int stop_at;
    calm    = 1'b1;
    gap_pct = 0;
    wait_idle();
    while (!out_tready) @(negedge clk);
    stop_at = items_sent + 120;
    while (items_sent < stop_at) begin
      build_random_line();
      send_line();
    end
  endtask

  // ------------------------------------------------------------------ main

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    out_tready = 1'b1;
    fail_cnt   = 0;
    items_sent = 0;
    gap_pct    = 0;
    calm       = 1'b0;
    load_char_sets();
    parser_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_lines();
    test_long_text();
    test_long_line();
    test_drain_pause();
    test_random_lines();
    test_steady_stream();

    wait_idle();
    repeat (10) @(negedge clk);
    if (token_q.size() != 0) begin
      $error("%0d results never arrived", token_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/ilc_pkg.sv
rtl/ilc_pair.sv
rtl/ilc_sect.sv
rtl/ini_line_classifier.sv
test/tb_ini_line_classifier.sv
